// ----- sv/tss_pkg.sv -----
package tss_pkg;

  localparam int COORD_W       = 13;
  localparam int ROW_W         = 10;
  localparam int COLOR_W       = 16;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;

  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NUM_W      = 2 * COORD_W;
  localparam int DIV_BITS   = COORD_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int XPOS_W     = DIFF_W + 1;
  localparam int EDGES      = 3;
  localparam int LANES      = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [ROW_W-1:0]          row;
    logic [COLOR_W-1:0]        fill_color;
  } tss_query_t;

  typedef struct packed {
    logic               span_valid;
    logic [ROW_W-1:0]   span_start;
    logic [ROW_W-1:0]   span_end;
    logic [ROW_W-1:0]   span_row;
    logic [COLOR_W-1:0] span_color;
  } tss_span_t;

  typedef struct packed {
    logic               ok;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } tss_meta_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  t;
    logic signed [DIFF_W-1:0]  dy;
  } tss_setup_lane_t;

  typedef struct packed {
    logic                              v;
    tss_meta_t                         meta;
    tss_setup_lane_t [LANES-1:0]       lane;
  } tss_setup_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic                      neg;
    logic [NUM_W-1:0]          rem;
    logic [COORD_W-1:0]        den;
    logic [DIV_BITS-1:0]       quo;
  } tss_div_lane_t;

  typedef struct packed {
    logic                        v;
    tss_meta_t                   meta;
    tss_div_lane_t [LANES-1:0]   lane;
  } tss_div_t;

endpackage

// ----- sv/tss_query_if.sv -----
interface tss_query_if;
  import tss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] ax;
  logic signed [COORD_W-1:0] ay;
  logic signed [COORD_W-1:0] bx;
  logic signed [COORD_W-1:0] by_coord;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic [ROW_W-1:0]          row;
  logic [COLOR_W-1:0]        fill_color;

  modport source (
    output valid, ax, ay, bx, by_coord, cx, cy, row, fill_color,
    input  ready
  );

  modport sink (
    input  valid, ax, ay, bx, by_coord, cx, cy, row, fill_color,
    output ready
  );

endinterface

// ----- sv/tss_span_if.sv -----
interface tss_span_if;
  import tss_pkg::*;

  logic               valid;
  logic               ready;
  logic               span_valid;
  logic [ROW_W-1:0]   span_start;
  logic [ROW_W-1:0]   span_end;
  logic [ROW_W-1:0]   span_row;
  logic [COLOR_W-1:0] span_color;

  modport source (
    output valid, span_valid, span_start, span_end, span_row, span_color,
    input  ready
  );

  modport sink (
    input  valid, span_valid, span_start, span_end, span_row, span_color,
    output ready
  );

endinterface

// ----- sv/tss_edge_setup.sv -----
module tss_edge_setup (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                vld,
  input  tss_pkg::tss_query_t qry,
  output tss_pkg::tss_setup_t stg
);
  import tss_pkg::*;

  localparam logic signed [DIFF_W-1:0] YMAX = DIFF_W'(SCREEN_HEIGHT - 1);

  tss_setup_t stg_next;

  always_comb begin
    logic signed [DIFF_W-1:0] xs [EDGES];
    logic signed [DIFF_W-1:0] ys [EDGES];
    logic signed [DIFF_W-1:0] r;
    logic signed [DIFF_W-1:0] lo;
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] x1;
    logic signed [DIFF_W-1:0] y1;
    logic signed [DIFF_W-1:0] dxe [EDGES];
    logic signed [DIFF_W-1:0] dye [EDGES];
    logic signed [DIFF_W-1:0] te  [EDGES];
    logic [EDGES-1:0]         hit;
    logic [1:0]               ia;
    logic [1:0]               ib;
    logic                     in_range;

    xs[0] = {qry.ax[COORD_W-1], qry.ax};
    ys[0] = {qry.ay[COORD_W-1], qry.ay};
    xs[1] = {qry.bx[COORD_W-1], qry.bx};
    ys[1] = {qry.by_coord[COORD_W-1], qry.by_coord};
    xs[2] = {qry.cx[COORD_W-1], qry.cx};
    ys[2] = {qry.cy[COORD_W-1], qry.cy};
    r = $signed({{(DIFF_W-ROW_W){1'b0}}, qry.row});

    lo = ys[0];
    hi = ys[0];
    for (int e = 1; e < EDGES; e++) begin
      if (ys[e] < lo) lo = ys[e];
      if (ys[e] > hi) hi = ys[e];
    end
    if (lo < 0) lo = '0;
    if (hi > YMAX) hi = YMAX;
    in_range = (r >= lo) && (r <= hi);

    for (int e = 0; e < EDGES; e++) begin
      x1 = xs[(e == EDGES - 1) ? 0 : e + 1];
      y1 = ys[(e == EDGES - 1) ? 0 : e + 1];
      hit[e] = ((ys[e] <= r) && (r < y1)) || ((y1 <= r) && (r < ys[e]));
      dxe[e] = x1 - xs[e];
      dye[e] = y1 - ys[e];
      te[e]  = r - ys[e];
    end

    ia = hit[0] ? 2'd0 : (hit[1] ? 2'd1 : 2'd2);
    ib = (hit[0] && hit[1]) ? 2'd1 : 2'd2;

    stg_next.v          = vld;
    stg_next.meta.ok    = in_range &&
                          ((hit[0] && hit[1]) || (hit[0] && hit[2]) || (hit[1] && hit[2]));
    stg_next.meta.row   = qry.row;
    stg_next.meta.color = qry.fill_color;

    stg_next.lane[0].x0 = xs[ia][COORD_W-1:0];
    stg_next.lane[0].dx = dxe[ia];
    stg_next.lane[0].t  = te[ia];
    stg_next.lane[0].dy = dye[ia];
    stg_next.lane[1].x0 = xs[ib][COORD_W-1:0];
    stg_next.lane[1].dx = dxe[ib];
    stg_next.lane[1].t  = te[ib];
    stg_next.lane[1].dy = dye[ib];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.v <= 1'b0;
    end else if (adv) begin
      stg <= stg_next;
    end
  end

endmodule

// ----- sv/tss_mult.sv -----
module tss_mult (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  tss_pkg::tss_setup_t stg,
  output tss_pkg::tss_div_t   dst
);
  import tss_pkg::*;

  logic                            prod_v;
  tss_meta_t                       prod_meta;
  logic signed [PROD_W-1:0]        prod   [LANES];
  logic signed [DIFF_W-1:0]        prod_dy[LANES];
  logic signed [COORD_W-1:0]       prod_x0[LANES];
  tss_div_t                        dst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else if (adv) begin
      prod_v    <= stg.v;
      prod_meta <= stg.meta;
      for (int l = 0; l < LANES; l++) begin
        prod[l]    <= $signed(stg.lane[l].dx) * $signed(stg.lane[l].t);
        prod_dy[l] <= stg.lane[l].dy;
        prod_x0[l] <= stg.lane[l].x0;
      end
    end
  end

  always_comb begin
    logic [PROD_W-1:0] pmag;
    logic [DIFF_W-1:0] dmag;

    dst_next.v    = prod_v;
    dst_next.meta = prod_meta;
    for (int l = 0; l < LANES; l++) begin
      pmag = prod[l][PROD_W-1] ? PROD_W'(-prod[l]) : PROD_W'(prod[l]);
      dmag = prod_dy[l][DIFF_W-1] ? DIFF_W'(-prod_dy[l]) : DIFF_W'(prod_dy[l]);
      dst_next.lane[l].x0  = prod_x0[l];
      dst_next.lane[l].neg = prod[l][PROD_W-1] ^ prod_dy[l][DIFF_W-1];
      dst_next.lane[l].rem = pmag[NUM_W-1:0];
      dst_next.lane[l].den = dmag[COORD_W-1:0];
      dst_next.lane[l].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.v <= 1'b0;
    end else if (adv) begin
      dst <= dst_next;
    end
  end

endmodule

// ----- sv/tss_div_pipe.sv -----
module tss_div_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  tss_pkg::tss_div_t src,
  output tss_pkg::tss_div_t dst
);
  import tss_pkg::*;

  tss_div_t stage     [DIV_STAGES];
  tss_div_t stage_next[DIV_STAGES];

  always_comb begin
    logic [NUM_W-1:0] trial;
    int               b;

    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_next[s] = (s == 0) ? src : stage[(s == 0) ? 0 : s - 1];
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          b = DIV_BITS - 1 - s * DIV_STEPS - j;
          if (b >= 0) begin
            trial = NUM_W'(stage_next[s].lane[l].den) << b;
            if (stage_next[s].lane[l].rem >= trial) begin
              stage_next[s].lane[l].rem = stage_next[s].lane[l].rem - trial;
              stage_next[s].lane[l].quo = {stage_next[s].lane[l].quo[DIV_BITS-2:0], 1'b1};
            end else begin
              stage_next[s].lane[l].quo = {stage_next[s].lane[l].quo[DIV_BITS-2:0], 1'b0};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stage[s].v <= 1'b0;
      end
    end else if (adv) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stage[s] <= stage_next[s];
      end
    end
  end

  assign dst = stage[DIV_STAGES-1];

endmodule

// ----- sv/tss_span_clip.sv -----
module tss_span_clip (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  tss_pkg::tss_div_t  src,
  output logic               out_v,
  output tss_pkg::tss_span_t out
);
  import tss_pkg::*;

  localparam logic signed [XPOS_W-1:0] XMAX = XPOS_W'(SCREEN_WIDTH - 1);

  logic                     pos_v;
  tss_meta_t                pos_meta;
  logic signed [XPOS_W-1:0] pos[LANES];

  always_ff @(posedge clk) begin
    logic signed [DIFF_W-1:0] q;

    if (rst) begin
      pos_v <= 1'b0;
    end else if (adv) begin
      pos_v    <= src.v;
      pos_meta <= src.meta;
      for (int l = 0; l < LANES; l++) begin
        q = src.lane[l].neg ? -$signed({1'b0, src.lane[l].quo})
                            :  $signed({1'b0, src.lane[l].quo});
        pos[l] <= $signed({{2{src.lane[l].x0[COORD_W-1]}}, src.lane[l].x0}) +
                  $signed({q[DIFF_W-1], q});
      end
    end
  end

  tss_span_t out_next;

  always_comb begin
    logic signed [XPOS_W-1:0] xa;
    logic signed [XPOS_W-1:0] xb;
    logic                     ok;

    xa = (pos[0] > pos[1]) ? pos[1] : pos[0];
    xb = (pos[0] > pos[1]) ? pos[0] : pos[1];
    if (xa < 0) xa = '0;
    if (xb > XMAX) xb = XMAX;
    ok = pos_meta.ok && (xb >= xa);

    out_next.span_valid = ok;
    out_next.span_start = ok ? xa[ROW_W-1:0] : '0;
    out_next.span_end   = ok ? xb[ROW_W-1:0] : '0;
    out_next.span_row   = pos_meta.row;
    out_next.span_color = pos_meta.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= pos_v;
      out   <= out_next;
    end
  end

endmodule

// ----- sv/triangle_scanline_span.sv -----
// Pipeline: setup, two multiplier stages, a seven stage divider (up to two
// quotient bits per stage) and two clip stages; one query per cycle
// is accepted while the output is not stalled.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all stage valid bits; no clearing pass.
module triangle_scanline_span (
  input  logic        clk,
  input  logic        rst,
  tss_query_if.sink   query,
  tss_span_if.source  span
);
  import tss_pkg::*;

  logic       adv;
  logic       out_v;
  tss_query_t qry;
  tss_setup_t setup_q;
  tss_div_t   mult_q;
  tss_div_t   div_q;
  tss_span_t  span_q;

  assign adv         = !out_v || span.ready;
  assign query.ready = adv;

  assign qry.ax         = query.ax;
  assign qry.ay         = query.ay;
  assign qry.bx         = query.bx;
  assign qry.by_coord   = query.by_coord;
  assign qry.cx         = query.cx;
  assign qry.cy         = query.cy;
  assign qry.row        = query.row;
  assign qry.fill_color = query.fill_color;

  tss_edge_setup u_setup (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .vld (query.valid),
    .qry (qry),
    .stg (setup_q)
  );

  tss_mult u_mult (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .stg (setup_q),
    .dst (mult_q)
  );

  tss_div_pipe u_div (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .src (mult_q),
    .dst (div_q)
  );

  tss_span_clip u_clip (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .src   (div_q),
    .out_v (out_v),
    .out   (span_q)
  );

  assign span.valid      = out_v;
  assign span.span_valid = span_q.span_valid;
  assign span.span_start = span_q.span_start;
  assign span.span_end   = span_q.span_end;
  assign span.span_row   = span_q.span_row;
  assign span.span_color = span_q.span_color;

endmodule
